FILE: hw/rtl/e2e8_pkg.sv
package e2e8_pkg;

   localparam int E2E8_MAX_FRAME_BYTES = 4096;
   localparam int E2E8_HDR_BYTES       = 20;
   localparam logic [31:0] E2E8_ALL_ONES  = 32'hFFFF_FFFF;
   localparam logic [31:0] E2E8_CRC_POLY  = 32'hC8DF_352F;

   // transaction kinds on the request channel
   localparam logic E2E8_REQ_FRAME_BYTE  = 1'b0;
   localparam logic E2E8_REQ_NO_NEW_DATA = 1'b1;

   // check modes
   localparam logic E2E8_CHECK_SOURCE = 1'b0;
   localparam logic E2E8_CHECK_SINK   = 1'b1;

   // configuration register indexes
   localparam int E2E8_CSR_IDX_W = 3;
   localparam logic [E2E8_CSR_IDX_W-1:0] E2E8_CSR_CHECK_MODE    = 3'd0;
   localparam logic [E2E8_CSR_IDX_W-1:0] E2E8_CSR_HEADER_OFFSET = 3'd1;
   localparam logic [E2E8_CSR_IDX_W-1:0] E2E8_CSR_MIN_LENGTH    = 3'd2;
   localparam logic [E2E8_CSR_IDX_W-1:0] E2E8_CSR_MAX_LENGTH    = 3'd3;
   localparam logic [E2E8_CSR_IDX_W-1:0] E2E8_CSR_DATA_ID       = 3'd4;
   localparam logic [E2E8_CSR_IDX_W-1:0] E2E8_CSR_MAX_DELTA     = 3'd5;

   typedef enum logic [2:0] {
      ST_OK             = 3'd0,
      ST_OK_SOME_LOST   = 3'd1,
      ST_ERROR          = 3'd2,
      ST_REPEATED       = 3'd3,
      ST_NO_NEW_DATA    = 3'd4,
      ST_WRONG_SEQUENCE = 3'd5
   } status_type;

   typedef struct packed {
      logic        req_type;
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [27:0] expected_source_id;
      logic        msg_type;
      logic        msg_result;
   } req_payload_type;

   typedef struct packed {
      status_type  check_status;
      logic        input_error;
      logic [27:0] received_source_id;
      logic [31:0] received_counter;
   } rsp_payload_type;

   typedef struct packed {
      logic        check_mode;
      logic [11:0] header_offset;
      logic [12:0] min_length;
      logic [12:0] max_length;
      logic [31:0] data_id;
      logic [31:0] max_delta;
   } cfg_type;

   // everything the evaluation stage needs about one finished frame
   typedef struct packed {
      logic        no_new_data;
      logic        len_bad;
      logic        len_match;
      logic [31:0] crc;
      logic [31:0] hdr_crc;
      logic [31:0] hdr_counter;
      logic [31:0] hdr_id;
      logic [31:0] hdr_source_word;
      logic [27:0] exp_source_id;
      logic        exp_type;
      logic        exp_result;
   } snap_type;

   // crc-32 p4, reflected, one byte
   function automatic logic [31:0] crc32p4_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'h0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ E2E8_CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

FILE: hw/rtl/e2e8_frame_asm.sv
module e2e8_frame_asm #(
   parameter int MAX_FRAME_BYTES = e2e8_pkg::E2E8_MAX_FRAME_BYTES
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      byte_fire,
   input  e2e8_pkg::req_payload_type item,
   input  e2e8_pkg::cfg_type         cfg,
   output e2e8_pkg::snap_type        snap
);

   localparam int PosW = $clog2(MAX_FRAME_BYTES + 2);
   localparam logic [PosW-1:0] PosSat = PosW'(MAX_FRAME_BYTES + 1);

   // header word slots, four bytes each
   localparam logic [2:0] WordCrc     = 3'd0;
   localparam logic [2:0] WordLength  = 3'd1;
   localparam logic [2:0] WordCounter = 3'd2;
   localparam logic [2:0] WordId      = 3'd3;

   logic [PosW-1:0] pos_ff, pos_in;
   logic [31:0]     crc_ff, crc_in;
   logic [31:0]     hdr_crc_ff, hdr_crc_in;
   logic [31:0]     hdr_len_ff, hdr_len_in;
   logic [31:0]     hdr_cnt_ff, hdr_cnt_in;
   logic [31:0]     hdr_id_ff, hdr_id_in;
   logic [31:0]     hdr_src_ff, hdr_src_in;

   logic [31:0] pos32;
   logic [31:0] off32;
   logic [31:0] hdr_end32;
   logic [31:0] len32;
   logic [4:0]  rel;
   logic        in_hdr;
   logic [31:0] crc_upd;

   always_comb begin
      pos32     = 32'(pos_ff);
      off32     = 32'(cfg.header_offset);
      hdr_end32 = off32 + 32'(e2e8_pkg::E2E8_HDR_BYTES);
      in_hdr    = (pos32 >= off32) && (pos32 < hdr_end32);
      rel       = 5'(pos32 - off32);
      crc_upd   = e2e8_pkg::crc32p4_byte(crc_ff, item.data_byte);

      hdr_crc_in = hdr_crc_ff;
      hdr_len_in = hdr_len_ff;
      hdr_cnt_in = hdr_cnt_ff;
      hdr_id_in  = hdr_id_ff;
      hdr_src_in = hdr_src_ff;
      crc_in     = crc_upd;
      if (in_hdr) begin
         case (rel[4:2])
            WordCrc: begin
               hdr_crc_in = {hdr_crc_ff[23:0], item.data_byte};
               // the crc field itself is not covered
               crc_in     = crc_ff;
            end
            WordLength:  hdr_len_in = {hdr_len_ff[23:0], item.data_byte};
            WordCounter: hdr_cnt_in = {hdr_cnt_ff[23:0], item.data_byte};
            WordId:      hdr_id_in  = {hdr_id_ff[23:0], item.data_byte};
            default:     hdr_src_in = {hdr_src_ff[23:0], item.data_byte};
         endcase
      end

      // byte count saturates one past the largest frame
      pos_in = (pos_ff < PosSat) ? pos_ff + PosW'(1) : pos_ff;
      len32  = 32'(pos_in);

      snap.no_new_data     = (item.req_type == e2e8_pkg::E2E8_REQ_NO_NEW_DATA);
      snap.len_bad         = (len32 < 32'(cfg.min_length)) || (len32 > 32'(cfg.max_length)) ||
                             (len32 > 32'(MAX_FRAME_BYTES)) || (len32 < hdr_end32);
      snap.len_match       = (hdr_len_in == len32);
      snap.crc             = crc_in;
      snap.hdr_crc         = hdr_crc_in;
      snap.hdr_counter     = hdr_cnt_in;
      snap.hdr_id          = hdr_id_in;
      snap.hdr_source_word = hdr_src_in;
      snap.exp_source_id   = item.expected_source_id;
      snap.exp_type        = item.msg_type;
      snap.exp_result      = item.msg_result;
   end

   always_ff @(posedge clock) begin
      if (reset || (byte_fire && item.last_byte)) begin
         pos_ff     <= '0;
         crc_ff     <= e2e8_pkg::E2E8_ALL_ONES;
         hdr_crc_ff <= '0;
         hdr_len_ff <= '0;
         hdr_cnt_ff <= '0;
         hdr_id_ff  <= '0;
         hdr_src_ff <= '0;
      end else if (byte_fire) begin
         pos_ff     <= pos_in;
         crc_ff     <= crc_in;
         hdr_crc_ff <= hdr_crc_in;
         hdr_len_ff <= hdr_len_in;
         hdr_cnt_ff <= hdr_cnt_in;
         hdr_id_ff  <= hdr_id_in;
         hdr_src_ff <= hdr_src_in;
      end
   end

endmodule

FILE: hw/rtl/e2e8_eval.sv
module e2e8_eval (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      snap_fire,
   input  e2e8_pkg::snap_type        snap,
   input  e2e8_pkg::cfg_type         cfg,
   output e2e8_pkg::rsp_payload_type rsp_data
);

   e2e8_pkg::status_type      last_status_ff, last_status_in;
   logic [31:0]               last_counter_ff, last_counter_in;
   e2e8_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic        crc_ok;
   logic        src_ok;
   logic        rtype;
   logic        rres;
   logic        ok;
   logic        reject;
   logic [31:0] delta;

   always_comb begin
      crc_ok = ((snap.crc ^ e2e8_pkg::E2E8_ALL_ONES) == snap.hdr_crc);
      rtype  = |snap.hdr_source_word[31:30];
      rres   = |snap.hdr_source_word[29:28];
      src_ok = (cfg.check_mode != e2e8_pkg::E2E8_CHECK_SOURCE) ||
               (snap.hdr_source_word[27:0] == snap.exp_source_id);
      ok     = crc_ok && (snap.hdr_id == cfg.data_id) && snap.len_match &&
               (rtype == snap.exp_type) && (rres == snap.exp_result) && src_ok;
      delta  = snap.hdr_counter - last_counter_ff;
      reject = snap.no_new_data || snap.len_bad;

      last_counter_in = last_counter_ff;
      if (snap.no_new_data) begin
         last_status_in = e2e8_pkg::ST_NO_NEW_DATA;
      end else if (snap.len_bad) begin
         last_status_in = last_status_ff;
      end else if (!ok) begin
         last_status_in = e2e8_pkg::ST_ERROR;
      end else begin
         last_counter_in = snap.hdr_counter;
         if (delta > cfg.max_delta) begin
            last_status_in = e2e8_pkg::ST_WRONG_SEQUENCE;
         end else if (delta == 32'd0) begin
            last_status_in = e2e8_pkg::ST_REPEATED;
         end else if (delta == 32'd1) begin
            last_status_in = e2e8_pkg::ST_OK;
         end else begin
            last_status_in = e2e8_pkg::ST_OK_SOME_LOST;
         end
      end

      rsp_data_in.check_status       = last_status_in;
      rsp_data_in.input_error        = !snap.no_new_data && snap.len_bad;
      rsp_data_in.received_source_id = reject ? 28'd0 : snap.hdr_source_word[27:0];
      rsp_data_in.received_counter   = reject ? 32'd0 : snap.hdr_counter;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_status_ff  <= e2e8_pkg::ST_ERROR;
         last_counter_ff <= e2e8_pkg::E2E8_ALL_ONES;
      end else if (snap_fire) begin
         last_status_ff  <= last_status_in;
         last_counter_ff <= last_counter_in;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

FILE: hw/rtl/e2e_p8m_frame_checker_top.sv
// e2e profile 8m receive check, one frame byte per request transaction.
// req channel: req_valid / req_stall carry req_data; req_type selects a frame
//   byte or a no-new-data event; last_byte closes the frame and carries the
//   expected source id, message type and message result.
// rsp channel: rsp_valid / rsp_stall carry rsp_data; one transaction per last
//   byte and per no-new-data event, none for other bytes.
// csr channel: csr_valid / csr_ready with csr_index and csr_wdata; csr_ready is
//   always high. write only while no frame or event is in flight.
// path: a result reaches rsp_valid through the input register, then the
//   byte/crc stage register, then the result register.
// throughput: one request transaction per cycle while req_stall is low, bounded
//   by the per-byte crc network in the byte stage.
// reset: frame assembly cleared, last status error, last counter all ones,
//   registers to their defaults (min length 20, max length 4096, max delta 1).
// stall: a stalled result holds; the byte stage keeps one finished frame behind
//   it, and req_stall rises only when a result-bearing request cannot move on.
module e2e_p8m_frame_checker_top #(
   parameter int MAX_FRAME_BYTES = e2e8_pkg::E2E8_MAX_FRAME_BYTES
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  e2e8_pkg::req_payload_type               req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output e2e8_pkg::rsp_payload_type               rsp_data,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [e2e8_pkg::E2E8_CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                             csr_wdata
);

   logic                      r0_valid_ff, r0_valid_in;
   e2e8_pkg::req_payload_type r0_data_ff;
   logic                      s1_valid_ff, s1_valid_in;
   e2e8_pkg::snap_type        s1_data_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   e2e8_pkg::cfg_type         cfg_ff, cfg_in;

   e2e8_pkg::snap_type snap;
   logic               rsp_free;
   logic               s1_free;
   logic               s1_move;
   logic               needs_s1;
   logic               r0_go;
   logic               byte_fire;

   always_comb begin
      rsp_free  = !rsp_valid_ff || !rsp_stall;
      s1_move   = s1_valid_ff && rsp_free;
      s1_free   = !s1_valid_ff || rsp_free;
      needs_s1  = (r0_data_ff.req_type == e2e8_pkg::E2E8_REQ_NO_NEW_DATA) ||
                  r0_data_ff.last_byte;
      r0_go     = r0_valid_ff && (!needs_s1 || s1_free);
      byte_fire = r0_go && (r0_data_ff.req_type == e2e8_pkg::E2E8_REQ_FRAME_BYTE);
      req_stall = r0_valid_ff && !r0_go;

      r0_valid_in  = req_stall ? 1'b1 : req_valid;
      s1_valid_in  = (r0_go && needs_s1) ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      rsp_valid_in = rsp_free ? s1_valid_ff : 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         r0_valid_ff  <= r0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         r0_data_ff <= req_data;
      end
      if (r0_go && needs_s1) begin
         s1_data_ff <= snap;
      end
   end

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            e2e8_pkg::E2E8_CSR_CHECK_MODE:    cfg_in.check_mode    = csr_wdata[0];
            e2e8_pkg::E2E8_CSR_HEADER_OFFSET: cfg_in.header_offset = csr_wdata[11:0];
            e2e8_pkg::E2E8_CSR_MIN_LENGTH:    cfg_in.min_length    = csr_wdata[12:0];
            e2e8_pkg::E2E8_CSR_MAX_LENGTH:    cfg_in.max_length    = csr_wdata[12:0];
            e2e8_pkg::E2E8_CSR_DATA_ID:       cfg_in.data_id       = csr_wdata;
            e2e8_pkg::E2E8_CSR_MAX_DELTA:     cfg_in.max_delta     = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.check_mode    <= e2e8_pkg::E2E8_CHECK_SOURCE;
         cfg_ff.header_offset <= 12'd0;
         cfg_ff.min_length    <= 13'd20;
         cfg_ff.max_length    <= 13'd4096;
         cfg_ff.data_id       <= 32'd0;
         cfg_ff.max_delta     <= 32'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;

   e2e8_frame_asm #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_frame_asm (
      .clock     (clock),
      .reset     (reset),
      .byte_fire (byte_fire),
      .item      (r0_data_ff),
      .cfg       (cfg_ff),
      .snap      (snap)
   );

   e2e8_eval u_eval (
      .clock     (clock),
      .reset     (reset),
      .snap_fire (s1_move),
      .snap      (s1_data_ff),
      .cfg       (cfg_ff),
      .rsp_data  (rsp_data)
   );

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_snap_to_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> rsp_valid_ff)
      else $error("finished frame did not reach the result register");

   a_snap_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !rsp_free) |=> (s1_valid_ff && $stable(s1_data_ff)))
      else $error("held frame snapshot was lost or changed");

   a_input_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data.input_error) |->
         (rsp_data.received_source_id == 28'd0 && rsp_data.received_counter == 32'd0))
      else $error("input error result carries header fields");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (r0_valid_ff && needs_s1 && s1_valid_ff && rsp_valid_ff))
      else $error("request stalled with room in the pipeline");
`endif

endmodule

FILE: verif/tb_e2e_p8m_frame_checker_top.sv
`timescale 1ns / 1ps

module tb_e2e_p8m_frame_checker_top;
   import e2e8_pkg::*;

   localparam int CLK_PERIOD     = 12;
   localparam int RESET_CYCLES   = 6;
   localparam int DRAIN_CYCLES   = 6;
   localparam int TIMEOUT_CYCLES = 2_000_000;
   localparam int MAX_BYTES      = E2E8_MAX_FRAME_BYTES;
   localparam int HDR            = E2E8_HDR_BYTES;

   // indexes past the register file, writes there must be ignored
   localparam logic [E2E8_CSR_IDX_W-1:0] CSR_IDX_SPARE_A = 3'd6;
   localparam logic [E2E8_CSR_IDX_W-1:0] CSR_IDX_SPARE_B = 3'd7;

   typedef struct {
      int          len;
      logic [31:0] len_field;
      logic [31:0] counter;
      logic [31:0] did;
      logic [3:0]  tr_bits;
      logic [27:0] src;
      logic        bad_crc;
      logic [27:0] exp_src;
      logic        exp_type;
      logic        exp_res;
      int          nnd_at;
   } frame_desc_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [E2E8_CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   // frame check model state
   cfg_type     cfg_copy;
   int          rx_pos;
   logic [31:0] rx_crc;
   logic [31:0] hdr_crc, hdr_len, hdr_cnt, hdr_id, hdr_word;
   logic [31:0] seen_counter;
   status_type  seen_status;

   rsp_payload_type expected_checks[$];

   int err_count       = 0;
   int items_sent      = 0;
   int results_checked = 0;
   int csr_writes      = 0;
   int hold_request    = 0;
   bit no_idle         = 1'b0;

   e2e_p8m_frame_checker_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic logic [31:0] crc_p4_step(input logic [31:0] acc, input logic [7:0] d);
      logic fb;
      for (int k = 0; k < 8; k++) begin
         fb  = acc[0] ^ d[k];
         acc = {1'b0, acc[31:1]} ^ (fb ? E2E8_CRC_POLY : 32'h0);
      end
      return acc;
   endfunction

   function automatic void clear_frame_state();
      rx_pos   = 0;
      rx_crc   = E2E8_ALL_ONES;
      hdr_crc  = '0;
      hdr_len  = '0;
      hdr_cnt  = '0;
      hdr_id   = '0;
      hdr_word = '0;
   endfunction

   function automatic void model_reset();
      cfg_copy.check_mode    = E2E8_CHECK_SOURCE;
      cfg_copy.header_offset = '0;
      cfg_copy.min_length    = 13'd20;
      cfg_copy.max_length    = 13'd4096;
      cfg_copy.data_id       = '0;
      cfg_copy.max_delta     = 32'd1;
      clear_frame_state();
      seen_counter = E2E8_ALL_ONES;
      seen_status  = ST_ERROR;
   endfunction

   function automatic void apply_csr(input logic [2:0] idx, input logic [31:0] val);
      case (idx)
         E2E8_CSR_CHECK_MODE:    cfg_copy.check_mode    = val[0];
         E2E8_CSR_HEADER_OFFSET: cfg_copy.header_offset = val[11:0];
         E2E8_CSR_MIN_LENGTH:    cfg_copy.min_length    = val[12:0];
         E2E8_CSR_MAX_LENGTH:    cfg_copy.max_length    = val[12:0];
         E2E8_CSR_DATA_ID:       cfg_copy.data_id       = val;
         E2E8_CSR_MAX_DELTA:     cfg_copy.max_delta     = val;
         default: ;
      endcase
   endfunction

   // advance the model by one accepted request transaction
   function automatic void track_req(input req_payload_type p);
      rsp_payload_type r;
      logic [31:0] step;
      logic [7:0]  top;
      int          rel;
      int          flen;
      int          off;
      logic        ok;
      r   = '0;
      off = int'(cfg_copy.header_offset);
      if (p.req_type == E2E8_REQ_NO_NEW_DATA) begin
         seen_status    = ST_NO_NEW_DATA;
         r.check_status = ST_NO_NEW_DATA;
         expected_checks.push_back(r);
         return;
      end
      if (rx_pos >= off && rx_pos < off + HDR) begin
         rel = rx_pos - off;
         case (rel / 4)
            0: hdr_crc  = {hdr_crc[23:0], p.data_byte};
            1: hdr_len  = {hdr_len[23:0], p.data_byte};
            2: hdr_cnt  = {hdr_cnt[23:0], p.data_byte};
            3: hdr_id   = {hdr_id[23:0], p.data_byte};
            default: hdr_word = {hdr_word[23:0], p.data_byte};
         endcase
         if (rel >= 4) rx_crc = crc_p4_step(rx_crc, p.data_byte);
      end else begin
         rx_crc = crc_p4_step(rx_crc, p.data_byte);
      end
      if (rx_pos < MAX_BYTES + 1) rx_pos++;
      if (!p.last_byte) return;

      flen = rx_pos;
      if (flen < int'(cfg_copy.min_length) || flen > int'(cfg_copy.max_length) ||
          flen > MAX_BYTES || flen < off + HDR) begin
         r.check_status = seen_status;
         r.input_error  = 1'b1;
         expected_checks.push_back(r);
         clear_frame_state();
         return;
      end

      top = hdr_word[31:24];
      ok  = ((rx_crc ^ E2E8_ALL_ONES) == hdr_crc) && (hdr_id == cfg_copy.data_id) &&
            (hdr_len == flen) && ((top[7:6] != 2'b00) == p.msg_type) &&
            ((top[5:4] != 2'b00) == p.msg_result);
      if (cfg_copy.check_mode == E2E8_CHECK_SOURCE && hdr_word[27:0] != p.expected_source_id)
         ok = 1'b0;
      if (!ok) begin
         seen_status = ST_ERROR;
      end else begin
         step = hdr_cnt - seen_counter;
         if (step > cfg_copy.max_delta) seen_status = ST_WRONG_SEQUENCE;
         else if (step == 0)            seen_status = ST_REPEATED;
         else if (step == 1)            seen_status = ST_OK;
         else                           seen_status = ST_OK_SOME_LOST;
         seen_counter = hdr_cnt;
      end
      r.check_status       = seen_status;
      r.received_source_id = hdr_word[27:0];
      r.received_counter   = hdr_cnt;
      expected_checks.push_back(r);
      clear_frame_state();
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      err_count++;
      if (err_count <= 50)
         $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
   endtask

   // receiver side: random stall runs, or one long counted hold-off on request
   initial begin : rsp_stall_driver
      int  run;
      int  held;
      logic s;
      run  = 0;
      held = 0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            held         = hold_request;
            hold_request = 0;
            run          = 0;
         end
         if (held > 0) begin
            rsp_stall <= 1'b1;
            held--;
         end else if (run > 0) begin
            run--;
         end else if (no_idle) begin
            rsp_stall <= 1'b0;
         end else begin
            s = ($urandom_range(0, 3) == 0);
            rsp_stall <= s;
            run = s ? pick_gap() : $urandom_range(0, 12);
         end
      end
   end

   always @(posedge clock) begin : result_check
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_checks.size() == 0) begin
            report_mismatch("result with no transaction pending",
                            32'(rsp_data.check_status), 32'd0);
         end else begin
            want = expected_checks.pop_front();
            results_checked++;
            if (rsp_data.check_status !== want.check_status)
               report_mismatch("check_status", 32'(rsp_data.check_status),
                               32'(want.check_status));
            if (rsp_data.input_error !== want.input_error)
               report_mismatch("input_error", 32'(rsp_data.input_error),
                               32'(want.input_error));
            if (rsp_data.received_source_id !== want.received_source_id)
               report_mismatch("received_source_id", 32'(rsp_data.received_source_id),
                               32'(want.received_source_id));
            if (rsp_data.received_counter !== want.received_counter)
               report_mismatch("received_counter", rsp_data.received_counter,
                               want.received_counter);
         end
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_req(input req_payload_type p);
      int gap;
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  <= p;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      track_req(p);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_event();
      logic [63:0] raw;
      req_payload_type p;
      raw = {$urandom, $urandom};
      p = raw[$bits(req_payload_type)-1:0];
      p.req_type = E2E8_REQ_NO_NEW_DATA;
      send_req(p);
   endtask

   task automatic send_frame(input frame_desc_type f);
      logic [7:0]  fb [];
      logic [31:0] hw [5];
      logic [31:0] c;
      logic [63:0] raw;
      req_payload_type p;
      int off;
      int n;
      off = int'(cfg_copy.header_offset);
      n   = (f.len > off + HDR) ? f.len : off + HDR;
      fb  = new[n];
      foreach (fb[i]) fb[i] = 8'($urandom);
      hw[1] = f.len_field;
      hw[2] = f.counter;
      hw[3] = f.did;
      hw[4] = {f.tr_bits, f.src};
      for (int w = 1; w < 5; w++)
         for (int k = 0; k < 4; k++) fb[off + 4 * w + k] = hw[w][31 - 8 * k -: 8];
      c = E2E8_ALL_ONES;
      for (int i = 0; i < f.len; i++)
         if (i < off || i >= off + 4) c = crc_p4_step(c, fb[i]);
      c = ~c;
      if (f.bad_crc) c ^= 32'h1 << $urandom_range(0, 31);
      for (int k = 0; k < 4; k++) fb[off + k] = c[31 - 8 * k -: 8];
      for (int i = 0; i < f.len; i++) begin
         if (i == f.nnd_at) send_event();
         raw = {$urandom, $urandom};
         p = raw[$bits(req_payload_type)-1:0];
         p.req_type  = E2E8_REQ_FRAME_BYTE;
         p.data_byte = fb[i];
         p.last_byte = (i == f.len - 1);
         if (p.last_byte) begin
            p.expected_source_id = f.exp_src;
            p.msg_type           = f.exp_type;
            p.msg_result         = f.exp_res;
         end
         send_req(p);
      end
   endtask

   function automatic int len_floor();
      int lo;
      lo = int'(cfg_copy.header_offset) + HDR;
      if (int'(cfg_copy.min_length) > lo) lo = int'(cfg_copy.min_length);
      return lo;
   endfunction

   function automatic int len_ceiling();
      return (int'(cfg_copy.max_length) > MAX_BYTES) ? MAX_BYTES : int'(cfg_copy.max_length);
   endfunction

   // a frame that passes every check under the current settings
   function automatic frame_desc_type good_frame(input logic [31:0] step);
      frame_desc_type f;
      logic [1:0] tb2, rb2;
      int lo, hi;
      lo = len_floor();
      hi = len_ceiling();
      if ($urandom_range(0, 19) != 0 && hi > lo + 24) hi = lo + 24;
      else if (hi > lo + 300) hi = lo + 300;
      f.len       = (hi >= lo) ? $urandom_range(lo, hi) : lo;
      f.len_field = f.len;
      f.counter   = seen_counter + step;
      f.did       = cfg_copy.data_id;
      f.exp_type  = 1'($urandom);
      f.exp_res   = 1'($urandom);
      tb2 = f.exp_type ? 2'($urandom_range(1, 3)) : 2'b00;
      rb2 = f.exp_res  ? 2'($urandom_range(1, 3)) : 2'b00;
      f.tr_bits   = {tb2, rb2};
      f.src       = 28'($urandom);
      f.exp_src   = f.src;
      f.bad_crc   = 1'b0;
      f.nnd_at    = -1;
      return f;
   endfunction

   function automatic logic [31:0] pick_step();
      logic [31:0] md;
      md = cfg_copy.max_delta;
      case ($urandom_range(0, 7))
         0:       return 32'd0;
         1, 2, 3: return 32'd1;
         4:       return (md >= 2) ? $urandom_range(2, md) : 32'd1;
         5:       return md;
         6:       return md + 32'd1;
         default: return $urandom;
      endcase
   endfunction

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, val);
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // called at a falling edge; waits until the block has nothing in flight
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_checks.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // upper write data bits above each register's width are random
   task automatic set_config(input logic mode, input int off, input int minl, input int maxl,
                             input logic [31:0] did, input logic [31:0] maxd);
      logic [31:0] v;
      settle();
      v = $urandom; v[0] = mode;             csr_write(E2E8_CSR_CHECK_MODE, v);
      v = $urandom; v[11:0] = 12'(off);      csr_write(E2E8_CSR_HEADER_OFFSET, v);
      v = $urandom; v[12:0] = 13'(minl);     csr_write(E2E8_CSR_MIN_LENGTH, v);
      v = $urandom; v[12:0] = 13'(maxl);     csr_write(E2E8_CSR_MAX_LENGTH, v);
      csr_write(E2E8_CSR_DATA_ID, did);
      csr_write(E2E8_CSR_MAX_DELTA, maxd);
   endtask

   task automatic test_reset_defaults();
      send_event();
      send_frame(good_frame(1));
      send_frame(good_frame(1));
   endtask

   task automatic test_counter_steps();
      frame_desc_type f;
      set_config(E2E8_CHECK_SOURCE, 0, 20, 4096, $urandom, 3);
      send_frame(good_frame(1));
      send_frame(good_frame(0));
      send_frame(good_frame(2));
      send_frame(good_frame(3));
      send_frame(good_frame(4));
      // counter wraps from all ones to zero
      f = good_frame(0);
      f.counter = E2E8_ALL_ONES;
      send_frame(f);
      send_frame(good_frame(1));
   endtask

   task automatic test_frame_errors();
      frame_desc_type f;
      set_config(E2E8_CHECK_SOURCE, 10, 0, 64, $urandom, 5);
      f = good_frame(1); f.bad_crc = 1'b1;                 send_frame(f);
      f = good_frame(1); f.did = ~f.did;                   send_frame(f);
      f = good_frame(1); f.len_field = f.len + 1;          send_frame(f);
      f = good_frame(1); f.exp_type = ~f.exp_type;         send_frame(f);
      f = good_frame(1); f.exp_res = ~f.exp_res;           send_frame(f);
      f = good_frame(1); f.exp_src = f.src ^ 28'h1;        send_frame(f);
      // event in the middle of a frame leaves the frame intact
      f = good_frame(1); f.nnd_at = 7;                     send_frame(f);
      // header not complete inside the frame, then a frame over the maximum length
      f = good_frame(1); f.len = 25; f.len_field = 25;     send_frame(f);
      f = good_frame(1); f.len = 70; f.len_field = 70;     send_frame(f);
      // sink mode only reports the source id, then a frame under the minimum length
      set_config(E2E8_CHECK_SINK, 0, 24, 40, $urandom, 5);
      f = good_frame(1); f.exp_src = ~f.src;               send_frame(f);
      f = good_frame(1); f.len = 21; f.len_field = 21;     send_frame(f);
   endtask

   task automatic test_register_limits();
      frame_desc_type f;
      no_idle = 1'b1;
      // header at the highest offset that fits a largest frame, frames end before the header does
      set_config(E2E8_CHECK_SINK, 4076, 4096, 4096, E2E8_ALL_ONES, E2E8_ALL_ONES);
      f = good_frame(1); f.len = $urandom_range(1, 40); f.len_field = f.len;
      send_frame(f);
      f = good_frame(5); f.len = $urandom_range(20, 60); f.len_field = f.len;
      send_frame(f);
      set_config(E2E8_CHECK_SOURCE, 0, 0, 4096, 32'h0, 32'h0);
      send_frame(good_frame(0));
      send_frame(good_frame(1));
      set_config(E2E8_CHECK_SOURCE, 0, 0, 0, 32'h0, 32'h0);
      send_frame(good_frame(1));
      send_event();
      settle();
      csr_write(CSR_IDX_SPARE_A, $urandom);
      csr_write(CSR_IDX_SPARE_B, $urandom);
      no_idle = 1'b0;
   endtask

   task automatic test_backpressure();
      set_config(E2E8_CHECK_SOURCE, 0, 20, 4096, $urandom, E2E8_ALL_ONES);
      no_idle      = 1'b1;
      hold_request = 400;
      repeat (8) begin
         send_frame(good_frame(pick_step()));
         if ($urandom_range(0, 2) == 0) send_event();
      end
      no_idle = 1'b0;
   endtask

   task automatic test_random_traffic();
      frame_desc_type f;
      int off, minl, maxl, stop_at, r, lo, hi;
      logic [31:0] maxd;
      for (int ph = 0; ph < 8; ph++) begin
         off  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         minl = $urandom_range(0, off + 24);
         maxl = ($urandom_range(0, 1) == 0) ? MAX_BYTES : off + HDR + $urandom_range(4, 40);
         case ($urandom_range(0, 4))
            0:       maxd = 32'd0;
            1:       maxd = 32'd1;
            2:       maxd = $urandom_range(2, 6);
            3:       maxd = $urandom;
            default: maxd = E2E8_ALL_ONES;
         endcase
         set_config(1'($urandom_range(0, 1)), off, minl, maxl, $urandom, maxd);
         no_idle = (ph == 5);
         stop_at = items_sent + 40;
         while (items_sent < stop_at) begin
            r = $urandom_range(0, 99);
            f = good_frame(pick_step());
            if (r < 70) begin
               if ($urandom_range(0, 19) == 0) f.nnd_at = $urandom_range(0, f.len - 1);
            end else if (r < 84) begin
               case ($urandom_range(0, 5))
                  0: f.bad_crc = 1'b1;
                  1: f.did ^= ($urandom | 32'h1);
                  2: f.len_field = ($urandom_range(0, 1) == 0) ? f.len + $urandom_range(1, 3)
                                                               : $urandom;
                  3: f.exp_type = ~f.exp_type;
                  4: f.exp_res = ~f.exp_res;
                  default: f.exp_src ^= 28'($urandom | 32'h1);
               endcase
            end else if (r < 92) begin
               lo = len_floor();
               hi = len_ceiling();
               if (hi < MAX_BYTES && $urandom_range(0, 1) == 0) f.len = hi + $urandom_range(1, 10);
               else f.len = $urandom_range(1, lo - 1);
               f.len_field = f.len;
            end
            if (r < 92) send_frame(f);
            else send_event();
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      model_reset();
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_counter_steps();
      test_frame_errors();
      test_register_limits();
      test_backpressure();
      test_random_traffic();
      settle();
      $display("covered %0d request transactions, %0d results checked, %0d register writes",
               items_sent, results_checked, csr_writes);
      $display("length window edges, largest offset, corrupt headers, events, long hold-off");
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("timeout with %0d results still pending", expected_checks.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/e2e8_pkg.sv
hw/rtl/e2e8_frame_asm.sv
hw/rtl/e2e8_eval.sv
hw/rtl/e2e_p8m_frame_checker_top.sv
verif/tb_e2e_p8m_frame_checker_top.sv
